[rtl/smc_pkg.sv]
// Shared types and constants for the sorted counted multiset.
`default_nettype none

package smc_pkg;

    localparam int VALUE_W        = 32;
    localparam int OPCODE_W       = 2;
    localparam int STATUS_W       = 3;
    localparam int USED_W         = 5;
    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_COUNT_BITS = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT     = 2'd0,
        OP_DELETE     = 2'd1,
        OP_REMOVE_MAX = 2'd2,
        OP_CLEAR      = 2'd3
    } smc_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_SATURATED = 3'd4
    } smc_status_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        smc_op_t              op;
        logic [VALUE_W-1:0]   value;
        logic                 cmp_en;
        logic                 upd_en;
        logic                 grow;
        logic                 shrink;
    } smc_cmd_t;

    // Per-cell compare results, registered in the compare cycle.
    typedef struct packed {
        logic lt;
        logic eq;
        logic eq_one;
        logic eq_max;
        logic top;
    } smc_flags_t;

endpackage

`default_nettype wire

[rtl/sorted_counted_multiset.sv]
// Sorted multiset with occurrence counts: controller and row of cells.
//
// Input channel (in_valid, in_stall, opcode, value) takes one command per
// item; output channel (out_valid, out_stall, status, removed_value,
// entries_used) returns exactly one result item per command, in order.
// A command runs through capture, a compare cycle in which every
// cell compares its value with the operand in parallel, and an update cycle
// in which every cell keeps, loads, shifts from a neighbour or adjusts its
// count. The result is registered at the end of the update cycle; a new
// command is taken only once the current one has left its update cycle.
// in_stall is high whenever a command is in progress.
// Reset empties the table (all counts zero) and clears out_valid; stored
// values are left as they are. When the receiver stalls, the result is held
// and a following command waits in its update cycle until the output
// register is free.
`default_nettype none

module sorted_counted_multiset #(
    parameter int ENTRIES    = smc_pkg::DEF_ENTRIES,
    parameter int COUNT_BITS = smc_pkg::DEF_COUNT_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [smc_pkg::OPCODE_W-1:0]  opcode,
    input  wire logic [smc_pkg::VALUE_W-1:0]   value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [smc_pkg::STATUS_W-1:0]       status,
    output logic [smc_pkg::VALUE_W-1:0]        removed_value,
    output logic [smc_pkg::USED_W-1:0]         entries_used
);
    import smc_pkg::*;

    localparam int OCC_W = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } state_t;

    state_t             state_reg, state_next;
    smc_op_t            op_reg, op_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic               out_valid_reg, out_valid_next;
    smc_status_t        status_reg, status_next;
    logic [VALUE_W-1:0] removed_reg, removed_next;

    smc_cmd_t              cmd;
    smc_flags_t            flags_arr [ENTRIES];
    logic [VALUE_W-1:0]    val_arr   [ENTRIES];
    logic [COUNT_BITS-1:0] cnt_arr   [ENTRIES];

    logic [ENTRIES-1:0] eq_vec, one_vec, max_vec, used_vec;
    logic [VALUE_W-1:0] top_val;
    logic               found, drop_entry, saturated, full, upd_go, accept;

    // Row of cells
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        logic                  left_lt;
        logic [VALUE_W-1:0]    left_val, right_val;
        logic [COUNT_BITS-1:0] left_cnt, right_cnt;

        if (i == 0)
        begin : g_first
            assign left_lt  = 1'b1;
            assign left_val = '0;
            assign left_cnt = '0;
        end
        else
        begin : g_inner_l
            assign left_lt  = flags_arr[i-1].lt;
            assign left_val = val_arr[i-1];
            assign left_cnt = cnt_arr[i-1];
        end

        if (i == ENTRIES - 1)
        begin : g_last
            assign right_val = '0;
            assign right_cnt = '0;
        end
        else
        begin : g_inner_r
            assign right_val = val_arr[i+1];
            assign right_cnt = cnt_arr[i+1];
        end

        smc_cell #(
            .COUNT_BITS (COUNT_BITS)
        ) u_slot (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .left_lt   (left_lt),
            .left_val  (left_val),
            .left_cnt  (left_cnt),
            .right_val (right_val),
            .right_cnt (right_cnt),
            .flags     (flags_arr[i]),
            .val       (val_arr[i]),
            .cnt       (cnt_arr[i])
        );

        assign eq_vec[i]   = flags_arr[i].eq;
        assign one_vec[i]  = flags_arr[i].eq_one;
        assign max_vec[i]  = flags_arr[i].eq_max;
        assign used_vec[i] = (cnt_arr[i] != '0);
    end

    always_comb
    begin
        top_val = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            top_val = top_val | (val_arr[i] & {VALUE_W{flags_arr[i].top}});
        end
    end

    assign found      = |eq_vec;
    assign drop_entry = |(eq_vec & one_vec);
    assign saturated  = |(eq_vec & max_vec);
    assign full       = (occ_reg == OCC_W'(ENTRIES));
    assign upd_go     = (state_reg == S_UPD) && (!out_valid_reg || !out_stall);
    assign accept     = in_valid && !in_stall;

    assign cmd.op     = op_reg;
    assign cmd.value  = value_reg;
    assign cmd.cmp_en = (state_reg == S_CMP);
    assign cmd.upd_en = upd_go;
    assign cmd.grow   = !found && !full;
    assign cmd.shrink = found && drop_entry;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        value_next     = value_reg;
        occ_next       = occ_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        removed_next   = removed_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = smc_op_t'(opcode);
                    value_next = value;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (upd_go)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    removed_next   = '0;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            if (found)
                            begin
                                if (saturated)
                                begin
                                    status_next = ST_SATURATED;
                                end
                            end
                            else if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                occ_next = occ_reg + OCC_W'(1);
                            end
                        end
                        OP_DELETE:
                        begin
                            if (!found)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else if (drop_entry)
                            begin
                                occ_next = occ_reg - OCC_W'(1);
                            end
                        end
                        OP_REMOVE_MAX:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                occ_next     = occ_reg - OCC_W'(1);
                                removed_next = top_val;
                            end
                        end
                        default:
                        begin
                            occ_next = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_INSERT;
            value_reg     <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            removed_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            value_reg     <= value_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            removed_reg   <= removed_next;
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign entries_used  = USED_W'(occ_reg);

    // Occupied cells must match the distinct-value count.
    a_occ_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_vec) == int'(occ_reg))
        else $error("occupancy differs from occupied cells");

    // Distinct values: at most one cell matches the operand.
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(eq_vec))
        else $error("more than one cell matched");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(ENTRIES))
        else $error("occupancy above table size");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_go && op_reg == OP_CLEAR) |=> (occ_reg == '0 && used_vec == '0))
        else $error("clear left entries behind");

endmodule

`default_nettype wire

[rtl/smc_cell.sv]
// One slot of the sorted table: value, count and compare flags.
`default_nettype none

module smc_cell #(
    parameter int COUNT_BITS = smc_pkg::DEF_COUNT_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire smc_pkg::smc_cmd_t             cmd,
    input  wire logic                          left_lt,
    input  wire logic [smc_pkg::VALUE_W-1:0]   left_val,
    input  wire logic [COUNT_BITS-1:0]         left_cnt,
    input  wire logic [smc_pkg::VALUE_W-1:0]   right_val,
    input  wire logic [COUNT_BITS-1:0]         right_cnt,
    output smc_pkg::smc_flags_t                flags,
    output logic [smc_pkg::VALUE_W-1:0]        val,
    output logic [COUNT_BITS-1:0]              cnt
);
    import smc_pkg::*;

    logic [VALUE_W-1:0]    val_reg, val_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    smc_flags_t            flags_reg, flags_next;
    logic                  used;

    assign used = (cnt_reg != '0);

    always_comb
    begin
        flags_next = flags_reg;
        if (cmd.cmp_en)
        begin
            flags_next.lt     = used && ($signed(val_reg) < $signed(cmd.value));
            flags_next.eq     = used && (val_reg == cmd.value);
            flags_next.eq_one = (cnt_reg == COUNT_BITS'(1));
            flags_next.eq_max = (cnt_reg == '1);
            flags_next.top    = used && (right_cnt == '0);
        end
    end

    always_comb
    begin
        val_next = val_reg;
        cnt_next = cnt_reg;
        if (cmd.upd_en)
        begin
            case (cmd.op)
                OP_INSERT:
                begin
                    if (cmd.grow && !flags_reg.lt)
                    begin
                        if (left_lt)
                        begin
                            val_next = cmd.value;
                            cnt_next = COUNT_BITS'(1);
                        end
                        else
                        begin
                            val_next = left_val;
                            cnt_next = left_cnt;
                        end
                    end
                    else if (flags_reg.eq && !flags_reg.eq_max)
                    begin
                        cnt_next = cnt_reg + COUNT_BITS'(1);
                    end
                end
                OP_DELETE:
                begin
                    if (cmd.shrink && !flags_reg.lt)
                    begin
                        val_next = right_val;
                        cnt_next = right_cnt;
                    end
                    else if (flags_reg.eq && !flags_reg.eq_one)
                    begin
                        cnt_next = cnt_reg - COUNT_BITS'(1);
                    end
                end
                OP_REMOVE_MAX:
                begin
                    if (flags_reg.top)
                    begin
                        cnt_next = '0;
                    end
                end
                default:
                begin
                    cnt_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            flags_reg <= '0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign flags = flags_reg;
    assign val   = val_reg;
    assign cnt   = cnt_reg;

endmodule

`default_nettype wire

[verif/smc_checker.sv]
// Checker for the sorted counted multiset: predicts each command's result and compares.
module smc_checker #(
    parameter int ENTRIES    = smc_pkg::DEF_ENTRIES,
    parameter int COUNT_BITS = smc_pkg::DEF_COUNT_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [smc_pkg::OPCODE_W-1:0] opcode,
    input  logic [smc_pkg::VALUE_W-1:0]  value,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [smc_pkg::STATUS_W-1:0] status,
    input  logic [smc_pkg::VALUE_W-1:0]  removed_value,
    input  logic [smc_pkg::USED_W-1:0]   entries_used,
    output int                           failures,
    output int                           outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import smc_pkg::*;

    typedef struct {
        smc_status_t        st;
        logic [VALUE_W-1:0] removed;
        logic [USED_W-1:0]  used;
    } outcome_t;

    logic signed [VALUE_W-1:0] tbl_val [ENTRIES];
    logic [COUNT_BITS-1:0]     tbl_cnt [ENTRIES];
    int                        tbl_used;
    outcome_t                  awaited_results [$];
    outcome_t                  want;
    int                        fail_count;
    int                        result_idx;

    function automatic outcome_t apply_command(input smc_op_t op,
                                               input logic signed [VALUE_W-1:0] v);
        outcome_t res;
        int       pos;
        res.st      = ST_OK;
        res.removed = '0;
        pos         = 0;
        while (pos < tbl_used && tbl_val[pos] < v)
            pos++;
        case (op)
            OP_INSERT:
            begin
                if (pos < tbl_used && tbl_val[pos] == v)
                begin
                    if (tbl_cnt[pos] == '1)
                        res.st = ST_SATURATED;
                    else
                        tbl_cnt[pos]++;
                end
                else if (tbl_used >= ENTRIES)
                    res.st = ST_FULL;
                else
                begin
                    for (int i = tbl_used; i > pos; i--)
                    begin
                        tbl_val[i] = tbl_val[i-1];
                        tbl_cnt[i] = tbl_cnt[i-1];
                    end
                    tbl_val[pos] = v;
                    tbl_cnt[pos] = COUNT_BITS'(1);
                    tbl_used++;
                end
            end
            OP_DELETE:
            begin
                if (pos >= tbl_used || tbl_val[pos] != v)
                    res.st = ST_NOT_FOUND;
                else if (tbl_cnt[pos] > 1)
                    tbl_cnt[pos]--;
                else
                begin
                    for (int i = pos; i + 1 < tbl_used; i++)
                    begin
                        tbl_val[i] = tbl_val[i+1];
                        tbl_cnt[i] = tbl_cnt[i+1];
                    end
                    tbl_used--;
                    tbl_cnt[tbl_used] = '0;
                end
            end
            OP_REMOVE_MAX:
            begin
                if (tbl_used == 0)
                    res.st = ST_EMPTY;
                else
                begin
                    tbl_used--;
                    res.removed       = tbl_val[tbl_used];
                    tbl_cnt[tbl_used] = '0;
                end
            end
            default:
            begin
                tbl_used = 0;
                for (int i = 0; i < ENTRIES; i++)
                    tbl_cnt[i] = '0;
            end
        endcase
        res.used = USED_W'(tbl_used);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                tbl_val[i] = '0;
                tbl_cnt[i] = '0;
            end
            tbl_used = 0;
            awaited_results.delete();
            fail_count = 0;
            result_idx = 0;
            failures    <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result %0d: unexpected item, status %0d removed %h used %0d",
                                 result_idx, status, removed_value, entries_used);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.st || removed_value !== want.removed ||
                        entries_used !== want.used)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"result %0d mismatch (expected/actual): status %0d/%0d ",
                                      "removed %h/%h used %0d/%0d"},
                                     result_idx, want.st, status, want.removed, removed_value,
                                     want.used, entries_used);
                    end
                end
                result_idx++;
            end
            if (in_valid && !in_stall)
                awaited_results.push_back(apply_command(smc_op_t'(opcode), value));
            failures    <= fail_count;
            outstanding <= awaited_results.size();
        end
    end

endmodule

[verif/tb_sorted_counted_multiset.sv]
// Testbench top for the sorted counted multiset: stimulus, flow control and verdict.
module tb_sorted_counted_multiset;
    timeunit 1ns;
    timeprecision 1ps;

    import smc_pkg::*;

    localparam int POOL_SIZE = 24;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [OPCODE_W-1:0] opcode    = OP_INSERT;
    logic [VALUE_W-1:0]  value     = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  removed_value;
    logic [USED_W-1:0]   entries_used;

    int                  sender_idle_pct = 0;
    int                  sink_stall_pct  = 0;
    int                  check_failures;
    int                  check_pending;
    logic [VALUE_W-1:0]  value_pool [POOL_SIZE];

    sorted_counted_multiset i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .removed_value (removed_value),
        .entries_used  (entries_used)
    );

    smc_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .removed_value (removed_value),
        .entries_used  (entries_used),
        .failures      (check_failures),
        .outstanding   (check_pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < sink_stall_pct);

    task automatic send_command(input smc_op_t op, input logic [VALUE_W-1:0] val);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        value    <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (check_pending != 0)
            @(posedge clk);
    endtask

    // Alternates growing and shrinking spells; some growing spells start with a clean fill
    task automatic run_random(input int n_items);
        bit                 growing;
        int                 spell_left;
        int unsigned        r;
        int                 base;
        smc_op_t            op;
        logic [VALUE_W-1:0] val;
        growing    = 1'b0;
        spell_left = 0;
        for (int k = 0; k < n_items; k++)
        begin
            if (spell_left == 0)
            begin
                growing    = !growing;
                spell_left = $urandom_range(20, 60);
                for (int j = 0; j < 6; j++)
                    value_pool[$urandom_range(5, POOL_SIZE - 1)] = $urandom;
                if (growing && $urandom_range(0, 2) == 0)
                begin
                    // seventeen distinct values: the last one meets a full table
                    send_command(OP_CLEAR, $urandom);
                    base = $urandom_range(0, POOL_SIZE - 1);
                    for (int j = 0; j <= DEF_ENTRIES; j++)
                        send_command(OP_INSERT, value_pool[(base + j) % POOL_SIZE]);
                end
            end
            spell_left--;
            r = $urandom_range(0, 99);
            if (growing)
                op = (r < 68) ? OP_INSERT : (r < 84) ? OP_DELETE :
                     (r < 98) ? OP_REMOVE_MAX : OP_CLEAR;
            else
                op = (r < 25) ? OP_INSERT : (r < 65) ? OP_DELETE :
                     (r < 97) ? OP_REMOVE_MAX : OP_CLEAR;
            if (op == OP_REMOVE_MAX || op == OP_CLEAR || $urandom_range(0, 9) == 0)
                val = $urandom;
            else
                val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_command(op, val);
        end
    endtask

    initial
    begin
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        value_pool[4] = 32'h0000_0001;
        for (int i = 5; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        sender_idle_pct = 18;
        sink_stall_pct <= 72;

        send_command(OP_REMOVE_MAX, 32'hDEAD_BEEF);
        send_command(OP_DELETE,     32'h0000_0000);
        send_command(OP_CLEAR,      32'h0000_0000);
        send_command(OP_INSERT,     32'h7FFF_FFFF);
        send_command(OP_INSERT,     32'h8000_0000);
        send_command(OP_INSERT,     32'h0000_0000);
        send_command(OP_INSERT,     32'hFFFF_FFFF);
        send_command(OP_INSERT,     32'hFFFF_FFFF);
        send_command(OP_INSERT,     32'h0000_0001);
        send_command(OP_DELETE,     32'h0000_0005);
        send_command(OP_DELETE,     32'hFFFF_FFFF);
        send_command(OP_DELETE,     32'hFFFF_FFFF);
        send_command(OP_REMOVE_MAX, 32'h0000_0000);
        send_command(OP_DELETE,     32'h8000_0000);
        send_command(OP_REMOVE_MAX, 32'hFFFF_FFFF);
        send_command(OP_REMOVE_MAX, 32'h0000_0000);
        send_command(OP_REMOVE_MAX, 32'h0000_0000);
        send_command(OP_INSERT,     32'h5555_5555);
        send_command(OP_INSERT,     32'hAAAA_AAAA);
        send_command(OP_CLEAR,      32'hFFFF_FFFF);

        run_random(560);
        drain();

        sender_idle_pct = 72;
        sink_stall_pct <= 18;
        run_random(560);
        drain();

        sender_idle_pct = 0;
        sink_stall_pct <= 0;
        // stack several copies of one value beside two other entries
        send_command(OP_CLEAR,  32'h0000_0000);
        send_command(OP_INSERT, 32'hFFFF_0000);
        send_command(OP_INSERT, 32'h0000_FFFF);
        repeat (4)
            send_command(OP_INSERT, 32'h1234_5678);
        send_command(OP_INSERT, 32'h1234_5678);
        send_command(OP_DELETE, 32'h1234_5678);
        send_command(OP_INSERT, 32'h1234_5678);
        send_command(OP_INSERT, 32'h1234_5678);
        send_command(OP_CLEAR,  32'h0000_0000);
        run_random(200);
        drain();

        repeat (10) @(posedge clk);
        if (check_failures == 0)
            $display("sorted_counted_multiset test passed");
        else
            $display("sorted_counted_multiset test failed");
        $finish;
    end

    initial
    begin
        #(12_000_000);
        $display("sorted_counted_multiset test failed");
        $finish;
    end

endmodule
